>>> sv/lcc_pkg.sv
package lcc_pkg;

  localparam int NumLines = 4;

  typedef logic [15:0] pos_t;
  typedef logic [11:0] margin_t;
  typedef logic [2:0]  sect_t;
  typedef logic [3:0]  mask_t;
  typedef logic [15:0] cnt_t;

  typedef enum logic [2:0] {
    REG_ACTIVE_LINES = 3'd0,
    REG_MARGIN       = 3'd1,
    REG_LINE_POS_0   = 3'd2,
    REG_LINE_POS_1   = 3'd3,
    REG_LINE_POS_2   = 3'd4,
    REG_LINE_POS_3   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    sect_t                  active_lines;
    margin_t                margin;
    pos_t [NumLines-1:0]    line_pos;
  } cfg_t;

  typedef struct packed {
    sect_t sector;
    mask_t in_mask;
    mask_t out_mask;
  } step_t;

  localparam sect_t   RstActiveLines = 3'd3;
  localparam margin_t RstMargin      = 12'd80;
  localparam pos_t    RstLinePos0    = 16'd5600;
  localparam pos_t    RstLinePos1    = 16'd6400;
  localparam pos_t    RstLinePos2    = 16'd7200;
  localparam pos_t    RstLinePos3    = 16'd0;

  localparam cnt_t    CntMax         = 16'hFFFF;

endpackage

>>> sv/lcc_cfg_regs.sv
module lcc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output logic          cfg_ready,
  output lcc_pkg::cfg_t cfg
);
  import lcc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_lines <= RstActiveLines;
      cfg_r.margin       <= RstMargin;
      cfg_r.line_pos[0]  <= RstLinePos0;
      cfg_r.line_pos[1]  <= RstLinePos1;
      cfg_r.line_pos[2]  <= RstLinePos2;
      cfg_r.line_pos[3]  <= RstLinePos3;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ACTIVE_LINES: cfg_r.active_lines <= cfg_data[2:0];
        REG_MARGIN:       cfg_r.margin       <= cfg_data[11:0];
        REG_LINE_POS_0:   cfg_r.line_pos[0]  <= cfg_data;
        REG_LINE_POS_1:   cfg_r.line_pos[1]  <= cfg_data;
        REG_LINE_POS_2:   cfg_r.line_pos[2]  <= cfg_data;
        REG_LINE_POS_3:   cfg_r.line_pos[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/lcc_step.sv
module lcc_step #(
  parameter int MAX_LINES = 4
) (
  input  lcc_pkg::cfg_t  cfg,
  input  lcc_pkg::pos_t  pos,
  input  logic           started,
  input  lcc_pkg::sect_t last_sector,
  output lcc_pkg::step_t res
);
  import lcc_pkg::*;

  localparam sect_t MaxL = 3'(MAX_LINES);

  sect_t n_use;
  sect_t now;
  sect_t now_m1;
  sect_t now_p1;
  mask_t up_ok;
  mask_t dn_ok;
  mask_t up_rng;
  mask_t dn_rng;
  logic [16:0] pos_pm;

  always_comb begin
    n_use  = (cfg.active_lines > MaxL) ? MaxL : cfg.active_lines;
    pos_pm = {1'b0, pos} + {5'b0, cfg.margin};
    now    = '0;
    for (int i = 0; i < NumLines; i++) begin
      if ((3'(i) < n_use) && (cfg.line_pos[i] < pos)) begin
        now = now + 3'd1;
      end
      up_ok[i]  = ({1'b0, cfg.line_pos[i]} + {5'b0, cfg.margin}) < {1'b0, pos};
      dn_ok[i]  = {1'b0, cfg.line_pos[i]} > pos_pm;
      up_rng[i] = (3'(i) >= last_sector) && (3'(i) < now);
      dn_rng[i] = (3'(i) >= now) && (3'(i) < last_sector);
    end
    now_m1 = now - 3'd1;
    now_p1 = now + 3'd1;

    res.sector   = last_sector;
    res.in_mask  = '0;
    res.out_mask = '0;
    if (!started) begin
      res.sector = now;
    end else if (last_sector < now) begin
      res.in_mask = up_rng & up_ok;
      res.sector  = up_ok[now_m1[1:0]] ? now : now_m1;
    end else if (last_sector > now) begin
      res.out_mask = dn_rng & dn_ok;
      res.sector   = dn_ok[now[1:0]] ? now : now_p1;
    end
  end

endmodule

>>> sv/line_crossing_counter_top.sv
// Line crossing counter. Each item is one object position (unsigned 12.4); each accepted
// item yields one result carrying the stored sector, the lines counted IN or OUT by this
// item and all eight saturating counters. Throughput is one item per clock unless out_ready
// stalls the result register: the input register feeds a single pass of compare logic (four
// line compares against position and margin) into the result register, and the sector and
// counters update as that result loads, which is also when out_valid rises. The
// configuration port is always ready; write it only while no item is in flight.
module line_crossing_counter_top #(
  parameter int MAX_LINES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_sector,
  output logic [3:0]  out_in_mask,
  output logic [3:0]  out_out_mask,
  output logic [15:0] out_in_count_0,
  output logic [15:0] out_in_count_1,
  output logic [15:0] out_in_count_2,
  output logic [15:0] out_in_count_3,
  output logic [15:0] out_out_count_0,
  output logic [15:0] out_out_count_1,
  output logic [15:0] out_out_count_2,
  output logic [15:0] out_out_count_3,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lcc_pkg::*;

  cfg_t  cfg;
  step_t res;

  logic  s1_valid_r;
  pos_t  pos_r;
  logic  out_valid_r;
  logic  started_r;
  sect_t last_sector_r;
  mask_t in_mask_r;
  mask_t out_mask_r;
  logic  advance;
  cnt_t  in_cnt  [NumLines];
  cnt_t  out_cnt [NumLines];

  lcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  lcc_step #(.MAX_LINES(MAX_LINES)) u_step (
    .cfg         (cfg),
    .pos         (pos_r),
    .started     (started_r),
    .last_sector (last_sector_r),
    .res         (res)
  );

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos_r <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      started_r     <= 1'b0;
      last_sector_r <= '0;
    end else if (advance) begin
      out_valid_r   <= 1'b1;
      started_r     <= 1'b1;
      last_sector_r <= res.sector;
    end else if (out_ready) begin
      out_valid_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_mask_r  <= res.in_mask;
      out_mask_r <= res.out_mask;
    end
  end

  for (genvar i = 0; i < NumLines; i++) begin : g_line
    if (i < MAX_LINES) begin : g_cnt
      cnt_t in_r;
      cnt_t out_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          in_r  <= '0;
          out_r <= '0;
        end else if (advance) begin
          if (res.in_mask[i] && (in_r != CntMax)) begin
            in_r <= in_r + 16'd1;
          end
          if (res.out_mask[i] && (out_r != CntMax)) begin
            out_r <= out_r + 16'd1;
          end
        end
      end
      assign in_cnt[i]  = in_r;
      assign out_cnt[i] = out_r;
    end else begin : g_none
      assign in_cnt[i]  = '0;
      assign out_cnt[i] = '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sector      = last_sector_r;
  assign out_in_mask     = in_mask_r;
  assign out_out_mask    = out_mask_r;
  assign out_in_count_0  = in_cnt[0];
  assign out_in_count_1  = in_cnt[1];
  assign out_in_count_2  = in_cnt[2];
  assign out_in_count_3  = in_cnt[3];
  assign out_out_count_0 = out_cnt[0];
  assign out_out_count_1 = out_cnt[1];
  assign out_out_count_2 = out_cnt[2];
  assign out_out_count_3 = out_cnt[3];

  a_masks_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((|out_in_mask) && (|out_out_mask)))
    else $error("IN and OUT counted in the same item");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sector <= 3'(MAX_LINES)))
    else $error("stored sector beyond line count");

  a_in_cnt_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_mask[0]) |-> (out_in_count_0 != 16'd0))
    else $error("line 0 IN counted but counter is zero");

  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((out_in_count_0 >= $past(out_in_count_0)) &&
                      (out_out_count_0 >= $past(out_out_count_0))))
    else $error("line 0 counter decreased");

endmodule
